// ----- hw/rtl/ptwa_pkg.sv -----
// ptwa_pkg: shared constants, codes and types of the peer table with ageing
// used by every module of the block, depends on nothing

package ptwa_pkg;

	// table geometry
	localparam int PEER_SLOTS = 16;
	localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int CNT_W      = $clog2(PEER_SLOTS + 1);
	localparam int CNT_SAT    = 31;

	// reset value of the timeout register
	localparam logic [31:0] TIMEOUT_RESET = 32'd300;

	// action codes
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_PRUNE  = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_EXISTING = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_PRUNE    = 3'd3;
	localparam logic [2:0] ST_READ     = 3'd4;

	// input item
	typedef struct packed {
		logic [1:0]  action;
		logic [47:0] peer_mac;
		logic [31:0] peer_height;
		logic [7:0]  peer_caps;
		logic [31:0] now_sec;
		logic [3:0]  slot_select;
	} item_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_index;
		logic [4:0]  active_count;
		logic [4:0]  expired_count;
		logic        entry_active;
		logic [47:0] entry_mac;
		logic [31:0] entry_height;
		logic [7:0]  entry_caps;
		logic [31:0] entry_first_seen;
		logic [31:0] entry_last_seen;
	} result_t;

	// one word of the slot memory
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] height;
		logic [7:0]  caps;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic read_sel;
		logic upd_write;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;
		logic result_busy;
	} stat_t;

	// clamp a slot count to the five-bit result field
	function automatic logic [4:0] sat_cnt(input logic [CNT_W-1:0] c);
		if (32'(c) > CNT_SAT) begin
			return 5'(CNT_SAT);
		end
		return 5'(c);
	endfunction

endpackage

// ----- hw/rtl/ptwa_ctrl.sv -----
// ptwa_ctrl: sequencer of the peer table, one item at a time
// depends on ptwa_pkg for the command, status and action codes

module ptwa_ctrl import ptwa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_action,
	input  stat_t      stat,
	output logic       item_stall,
	output cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       prune_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (item_action) inside
						ACT_UPDATE, ACT_PRUNE: state_d = S_SCAN;
						ACT_READ:              state_d = S_READ;
						default:               state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = prune_q ? S_DONE : S_WRITE;
			end
			S_WRITE: begin
				cmd.upd_write = 1'b1;
				state_d       = S_DONE;
			end
			S_READ: begin
				cmd.read_sel = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!stat.result_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register and action mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prune_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				prune_q <= (item_action == ACT_PRUNE);
			end
		end
	end

	assign item_stall = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/ptwa_datapath.sv -----
// ptwa_datapath: slot memory, active and written flags, scan compare and result register
// depends on ptwa_pkg; driven by commands from ptwa_ctrl

module ptwa_datapath import ptwa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	input  logic        result_stall,
	output logic        result_valid,
	output result_t     result
);

	// slot memory, no reset: the written flags mask entries never filled
	entry_t mem_q [PEER_SLOTS];
	entry_t rdata_q;

	logic [PEER_SLOTS-1:0] active_q;
	logic [PEER_SLOTS-1:0] written_q;

	item_t             item_q;
	logic [31:0]       timeout_q;
	logic [SLOT_W-1:0] scan_addr_q;
	logic              stage_s1;
	logic [SLOT_W-1:0] addr_s1;

	logic              hit_found_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [31:0]       hit_first_q;
	logic [CNT_W-1:0]  live_cnt_q;
	logic [CNT_W-1:0]  exp_cnt_q;
	logic [4:0]        active_total_q;
	logic [2:0]        upd_status_q;
	logic [3:0]        upd_idx_q;
	logic              result_valid_q;
	result_t           result_q;

	logic              is_prune;
	logic [31:0]       age;
	logic              expire;
	logic              mac_hit;
	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] tgt;
	logic              upd_we;
	logic              we;
	logic [SLOT_W-1:0] waddr;
	entry_t            wdata;
	logic              re;
	logic [SLOT_W-1:0] raddr;
	logic [SLOT_W-1:0] sel_addr;
	logic              sel_ok;
	result_t           res_d;

	assign is_prune = (item_q.action == ACT_PRUNE);
	assign sel_addr = SLOT_W'(item_q.slot_select);
	assign sel_ok   = (32'(item_q.slot_select) < PEER_SLOTS);

	// compare stage on the word read in the previous cycle
	assign age     = item_q.now_sec - rdata_q.last_seen;
	assign expire  = stage_s1 && is_prune && active_q[addr_s1] && (age > timeout_q);
	assign mac_hit = stage_s1 && !is_prune && !hit_found_q && active_q[addr_s1] &&
	                 (rdata_q.mac == item_q.peer_mac);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign tgt    = hit_found_q ? hit_idx_q : free_idx;
	assign upd_we = cmd.upd_write && (hit_found_q || free_any);

	// write port select: expiry write-back or beacon write
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rdata_q;
		if (expire) begin
			we        = 1'b1;
			wdata.mac = '0;
		end else if (upd_we) begin
			we               = 1'b1;
			waddr            = tgt;
			wdata.mac        = item_q.peer_mac;
			wdata.height     = item_q.peer_height;
			wdata.caps       = item_q.peer_caps;
			wdata.first_seen = hit_found_q ? hit_first_q : item_q.now_sec;
			wdata.last_seen  = item_q.now_sec;
		end
	end

	// read port select
	assign re    = cmd.scan || cmd.read_sel;
	assign raddr = cmd.scan ? scan_addr_q : sel_addr;

	// slot memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// payload registers of the current item and scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q      <= item;
			scan_addr_q <= '0;
			live_cnt_q  <= '0;
			exp_cnt_q   <= '0;
		end else begin
			if (cmd.scan) begin
				scan_addr_q <= (scan_addr_q == SLOT_W'(PEER_SLOTS - 1)) ?
				               '0 : scan_addr_q + SLOT_W'(1);
			end
			if (stage_s1 && is_prune && active_q[addr_s1]) begin
				if (expire) begin
					exp_cnt_q <= exp_cnt_q + CNT_W'(1);
				end else begin
					live_cnt_q <= live_cnt_q + CNT_W'(1);
				end
			end
		end
		if (cmd.scan) begin
			addr_s1 <= scan_addr_q;
		end
		if (mac_hit) begin
			hit_idx_q   <= addr_s1;
			hit_first_q <= rdata_q.first_seen;
		end
		if (cmd.upd_write) begin
			if (hit_found_q) begin
				upd_status_q <= ST_EXISTING;
				upd_idx_q    <= 4'(hit_idx_q);
			end else if (free_any) begin
				upd_status_q <= ST_NEW;
				upd_idx_q    <= 4'(free_idx);
			end else begin
				upd_status_q <= ST_FULL;
				upd_idx_q    <= '0;
			end
		end
		if (cmd.finish) begin
			result_q <= res_d;
		end
	end

	// control state: flags, counters, timeout and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= '0;
			written_q      <= '0;
			stage_s1       <= 1'b0;
			hit_found_q    <= 1'b0;
			active_total_q <= '0;
			timeout_q      <= TIMEOUT_RESET;
			result_valid_q <= 1'b0;
		end else begin
			stage_s1 <= cmd.scan;
			if (cmd.load) begin
				hit_found_q <= 1'b0;
			end else if (mac_hit) begin
				hit_found_q <= 1'b1;
			end
			if (upd_we) begin
				active_q[tgt]  <= 1'b1;
				written_q[tgt] <= 1'b1;
			end
			if (expire) begin
				active_q[addr_s1] <= 1'b0;
			end
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (cmd.finish && is_prune) begin
				active_total_q <= sat_cnt(live_cnt_q);
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// result assembly
	always_comb begin
		res_d              = '0;
		res_d.active_count = active_total_q;
		unique case (item_q.action)
			ACT_UPDATE: begin
				res_d.status     = upd_status_q;
				res_d.slot_index = upd_idx_q;
			end
			ACT_PRUNE: begin
				res_d.status        = ST_PRUNE;
				res_d.active_count  = sat_cnt(live_cnt_q);
				res_d.expired_count = sat_cnt(exp_cnt_q);
			end
			ACT_READ: begin
				res_d.status     = ST_READ;
				res_d.slot_index = item_q.slot_select;
				if (sel_ok) begin
					res_d.entry_active = active_q[sel_addr];
					if (written_q[sel_addr]) begin
						res_d.entry_mac        = rdata_q.mac;
						res_d.entry_height     = rdata_q.height;
						res_d.entry_caps       = rdata_q.caps;
						res_d.entry_first_seen = rdata_q.first_seen;
						res_d.entry_last_seen  = rdata_q.last_seen;
					end
				end
			end
			default: begin
				res_d.status = ST_READ;
			end
		endcase
	end

	assign stat.scan_last   = (scan_addr_q == SLOT_W'(PEER_SLOTS - 1));
	assign stat.result_busy = result_valid_q && result_stall;
	assign result_valid     = result_valid_q;
	assign result           = result_q;

endmodule

// ----- hw/rtl/peer_table_with_aging.sv -----
// peer_table_with_aging: top level of the neighbour table with timeout
// depends on ptwa_pkg, ptwa_ctrl and ptwa_datapath

// The block holds PEER_SLOTS neighbour slots (16) in a single-port-read
// memory plus per-slot active and written flags in flip-flops, so it is
// usable straight out of reset with no clearing pass. It works on one item
// at a time. A beacon update walks every slot once through the memory read
// port looking for an active matching address, then writes one word to the
// matching slot or else the lowest free slot, if any. A prune walks the
// slots the same way, writing back expired entries as it goes. A read
// fetches the selected slot through the same read port. Action 3 is taken
// from idle, with no result. The result sits in an output register, and
// the next item is taken while it waits; a further result waits for that
// register to empty. The timeout register can be written at any time the
// block is idle, cfg_ready is always high.

module peer_table_with_aging import ptwa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	ptwa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_action (item.action),
		.stat        (stat),
		.item_stall  (item_stall),
		.cmd         (cmd)
	);

	// table and result path
	ptwa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	assign cfg_ready = 1'b1;

endmodule

// ----- hw/rtl/ptwa_checker.sv -----
// ptwa_checker: port-level checks on the results of the peer table
// depends on ptwa_pkg; bound to peer_table_with_aging below

module ptwa_checker import ptwa_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	// a full table reports no slot
	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_FULL) |-> (result.slot_index == 4'd0))
		else $error("table full result carries a slot index");

	// only a prune reports expiries
	a_exp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_PRUNE) |-> (result.expired_count == 5'd0))
		else $error("expired count outside a prune");

	// entry contents only come with a read
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_READ) |->
		!result.entry_active && (result.entry_mac == 48'd0))
		else $error("entry contents outside a read");

	// live plus expired never exceeds the table size
	a_prune_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_PRUNE) |->
		(32'(result.active_count) + 32'(result.expired_count) <= PEER_SLOTS))
		else $error("prune counts exceed the slot count");

endmodule

bind peer_table_with_aging ptwa_checker u_ptwa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
